// ----- rtl/core/mmm_pkg.sv -----
// Shared types and constants for the modular matrix multiplier.
// No dependencies; mmm_cell, the top level and the testbench import this package.
`default_nettype none
package mmm_pkg;

    localparam int MOD_W     = 31;  // modulus width, also remainder width
    localparam int CFG_W     = 31;  // configuration write data width
    localparam int CFG_IDX_W = 3;
    localparam int DIM_W     = 4;   // dimension register width
    localparam int POS_W     = 3;   // row/column field width on the ports
    localparam int VAL_W     = 32;  // product value width on the ports

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 3'd4;

    localparam logic [1:0] FN_LOAD_A = 2'd0;
    localparam logic [1:0] FN_LOAD_B = 2'd1;
    localparam logic [1:0] FN_START  = 2'd2;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_MISMATCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_ADD,
        ST_ABS,
        ST_DIV,
        ST_RESULT
    } t_state;

    // Control that travels with a remainder token along the cell chain.
    typedef struct packed {
        logic valid;
        logic neg;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- rtl/core/mmm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/mmm_cell.sv -----
// One restoring-remainder cell: folds one magnitude bit into the remainder.
// Depends on mmm_pkg.
`default_nettype none
module mmm_cell
    import mmm_pkg::*;
#(
    parameter int MAG_W = 65
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [MOD_W-1:0] i_modulus,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [MOD_W-1:0] i_rem,
    input  wire logic [MAG_W-1:0] i_mag,
    output t_cell_ctl             o_ctl,
    output logic      [MOD_W-1:0] o_rem,
    output logic      [MAG_W-1:0] o_mag
);
    logic [MOD_W:0]   w_trial;
    logic [MOD_W:0]   w_diff;
    logic [MOD_W-1:0] n_rem;

    // The remainder stays below the modulus, so one subtract restores it.
    always_comb begin
        w_trial = {i_rem, i_mag[MAG_W-1]};
        w_diff  = w_trial - {1'b0, i_modulus};
        if (w_trial >= {1'b0, i_modulus}) begin
            n_rem = w_diff[MOD_W-1:0];
        end else begin
            n_rem = w_trial[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else begin
            o_ctl <= i_ctl;
        end
        o_rem <= n_rem;
        o_mag <= {i_mag[MAG_W-2:0], 1'b0};
    end
endmodule
`default_nettype wire

// ----- rtl/core/modular_matrix_multiply_unit.sv -----
// Top level of the modular matrix multiplier: sequencer, element stores,
// multiplier and remainder cell chain. Depends on mmm_pkg, mmm_ram, mmm_cell.
//
// Usage. Items enter on the input channel (i_in_valid / o_in_ready). A load
// beat writes one element of A or B and gives no result; loads stream at
// one beat per cycle while no run is under way. A start beat runs C = A x B
// and sends every element of C in row-major order on the output channel
// (o_out_valid / i_out_ready), the final one flagged by o_last. If the column
// count of A differs from the row count of B, a single error beat with
// o_status set and o_last set is sent instead.
// Each element of C is built one product at a time: fetch, multiply, add,
// take the magnitude, then a chain of MAG_W remainder cells (one bit per
// cell, 64 cells at the default width) folds the sum modulo the modulus.
// An element takes a_cols inner steps plus the output handshake; each step
// passes the fetch, multiply, add and magnitude states, then waits until
// its token leaves the chain; only one token is in the chain at a time.
// The input side is closed during a run. When the receiver stalls, the
// finished element is held in the output register and the walk waits.
// Reset sets the configuration registers to 1, returns to idle, empties
// the chain; the stores keep their contents, undefined until written.
`default_nettype none
module modular_matrix_multiply_unit
    import mmm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // Input channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_func,
    input  wire logic [POS_W-1:0]     i_row_index,
    input  wire logic [POS_W-1:0]     i_col_index,
    input  wire logic [ELEM_BITS-1:0] i_element,
    // Output channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic      [POS_W-1:0]     o_out_row,
    output logic      [POS_W-1:0]     o_out_col,
    output logic      [VAL_W-1:0]     o_product_value,
    output logic                      o_status,
    output logic                      o_last
);
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = 2 * ELEM_BITS;
    // The sum of a product and a running remainder never needs more.
    localparam int SUM_W = ((PW > VAL_W) ? PW : VAL_W) + 1;
    localparam int MAG_W = SUM_W - 1;

    // Configuration registers.
    logic [MOD_W-1:0] r_modulus;
    logic [DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= MOD_W'(1);
            r_a_rows  <= DIM_W'(1);
            r_a_cols  <= DIM_W'(1);
            r_b_rows  <= DIM_W'(1);
            r_b_cols  <= DIM_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MODULUS: r_modulus <= i_cfg_data[MOD_W-1:0];
                CFG_A_ROWS:  r_a_rows  <= i_cfg_data[DIM_W-1:0];
                CFG_A_COLS:  r_a_cols  <= i_cfg_data[DIM_W-1:0];
                CFG_B_ROWS:  r_b_rows  <= i_cfg_data[DIM_W-1:0];
                CFG_B_COLS:  r_b_cols  <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // A dimension of zero acts as one, anything above MAX_DIM as MAX_DIM.
    // The result is the last valid index.
    function automatic logic [IW-1:0] last_index(input logic [DIM_W-1:0] d);
        logic [IW-1:0] v;
        if (d == '0) begin
            v = '0;
        end else if (int'(d) > MAX_DIM) begin
            v = IW'(MAX_DIM - 1);
        end else begin
            v = IW'(int'(d) - 1);
        end
        return v;
    endfunction

    t_state r_state, n_state;

    logic w_in_beat, w_out_beat, w_inject, w_in_range, w_mismatch;
    logic w_step_last, w_elem_last;

    logic [IW-1:0] r_i, r_j, r_k;
    logic [IW-1:0] r_ar_m1, r_ac_m1, r_bc_m1;
    logic [MOD_W-1:0] r_mod_eff;

    logic [ELEM_BITS-1:0] w_rd_a, w_rd_b;
    logic [AW-1:0] w_waddr, w_raddr_a, w_raddr_b;
    logic signed [PW-1:0]    r_prod;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [VAL_W-1:0] r_acc;
    logic signed [VAL_W-1:0] w_rem_val;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_beat = o_out_valid && i_out_ready;
    assign w_in_range = (int'(i_row_index) < MAX_DIM) && (int'(i_col_index) < MAX_DIM);
    assign w_mismatch = last_index(r_a_cols) != last_index(r_b_rows);

    // Element stores.
    assign w_waddr   = AW'(int'(i_row_index) * MAX_DIM + int'(i_col_index));
    assign w_raddr_a = AW'(int'(r_i) * MAX_DIM + int'(r_k));
    assign w_raddr_b = AW'(int'(r_k) * MAX_DIM + int'(r_j));

    mmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_in_beat && (i_func == FN_LOAD_A) && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_element),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    mmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_in_beat && (i_func == FN_LOAD_B) && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_element),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    // Remainder cell chain. Tap 0 is the injection point; tap MAG_W is the
    // finished remainder.
    t_cell_ctl        w_ctl [MAG_W+1];
    logic [MOD_W-1:0] w_rem [MAG_W+1];
    logic [MAG_W-1:0] w_mag [MAG_W+1];

    assign w_ctl[0] = {w_inject, r_sum[SUM_W-1]};
    assign w_rem[0] = '0;
    assign w_mag[0] = r_sum[SUM_W-1] ? MAG_W'(-r_sum) : MAG_W'(r_sum);

    for (genvar g = 0; g < MAG_W; g++) begin : g_cell
        mmm_cell #(.MAG_W(MAG_W)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_modulus (r_mod_eff),
            .i_ctl     (w_ctl[g]),
            .i_rem     (w_rem[g]),
            .i_mag     (w_mag[g]),
            .o_ctl     (w_ctl[g+1]),
            .o_rem     (w_rem[g+1]),
            .o_mag     (w_mag[g+1])
        );
    end

    // The remainder takes the sign of the sum it came from.
    assign w_rem_val = w_ctl[MAG_W].neg ? -VAL_W'(w_rem[MAG_W]) : VAL_W'(w_rem[MAG_W]);

    assign w_step_last = r_k == r_ac_m1;
    assign w_elem_last = (r_i == r_ar_m1) && (r_j == r_bc_m1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat && (i_func == FN_START)) begin
                    n_state = w_mismatch ? ST_RESULT : ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_MUL;
            ST_MUL:   n_state = ST_ADD;
            ST_ADD:   n_state = ST_ABS;
            ST_ABS:   n_state = ST_DIV;
            ST_DIV: begin
                if (w_ctl[MAG_W].valid) begin
                    n_state = w_step_last ? ST_RESULT : ST_FETCH;
                end
            end
            ST_RESULT: begin
                if (w_out_beat) begin
                    n_state = o_last ? ST_IDLE : ST_FETCH;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_inject    = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready  = 1'b1;
            ST_ABS:    w_inject    = 1'b1;
            ST_RESULT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Walk counters, accumulator and result register.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat && (i_func == FN_START)) begin
                    r_i       <= '0;
                    r_j       <= '0;
                    r_k       <= '0;
                    r_acc     <= '0;
                    r_ar_m1   <= last_index(r_a_rows);
                    r_ac_m1   <= last_index(r_a_cols);
                    r_bc_m1   <= last_index(r_b_cols);
                    r_mod_eff <= (r_modulus == '0) ? MOD_W'(1) : r_modulus;
                    o_out_row       <= '0;
                    o_out_col       <= '0;
                    o_product_value <= '0;
                    o_status        <= STATUS_MISMATCH;
                    o_last          <= 1'b1;
                end
            end
            ST_MUL: r_prod <= $signed(w_rd_a) * $signed(w_rd_b);
            ST_ADD: r_sum  <= SUM_W'(r_acc) + SUM_W'(r_prod);
            ST_DIV: begin
                if (w_ctl[MAG_W].valid) begin
                    r_acc <= w_rem_val;
                    if (w_step_last) begin
                        o_out_row       <= POS_W'(r_i);
                        o_out_col       <= POS_W'(r_j);
                        o_product_value <= w_rem_val;
                        o_status        <= STATUS_OK;
                        o_last          <= w_elem_last;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_beat && !o_last) begin
                    r_k   <= '0;
                    r_acc <= '0;
                    if (r_j == r_bc_m1) begin
                        r_j <= '0;
                        r_i <= r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // The input side and the output side are never open at once.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output open together");

    // A finished remainder only arrives while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl[MAG_W].valid |-> (r_state == ST_DIV))
        else $error("remainder token arrived outside the wait state");

    // An error beat is always the only and final beat of its run.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_last && (o_product_value == '0)))
        else $error("malformed error beat");

    // An injected token always leaves the far end of the cell chain.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_inject |-> ##(MAG_W) w_ctl[MAG_W].valid)
        else $error("cell chain lost a token");

endmodule
`default_nettype wire

// ----- dv/modular_matrix_multiply_unit_tb.sv -----
// Self-checking testbench for the modular matrix multiplier.
// Depends on mmm_pkg and the modular_matrix_multiply_unit RTL.
`timescale 1ns / 1ps
module modular_matrix_multiply_unit_tb;
    import mmm_pkg::*;

    localparam int N = 8;
    localparam int STEP_CYC = 68;          // cycles of one inner accumulation step
    localparam int WD_LIMIT = 400000;      // cycles with no beat before giving up

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] elem;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        status;
        logic        last;
    } t_prod;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [30:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_func = '0;
    logic [2:0]  i_row_index = '0;
    logic [2:0]  i_col_index = '0;
    logic [31:0] i_element = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_out_row;
    logic [2:0]  o_out_col;
    logic [31:0] o_product_value;
    logic        o_status;
    logic        o_last;

    modular_matrix_multiply_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_func(i_func), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_element(i_element),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_row(o_out_row), .o_out_col(o_out_col),
        .o_product_value(o_product_value), .o_status(o_status), .o_last(o_last)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Shadow copy of the block state, kept by the predictor.
    longint    mat_a [N*N];
    longint    mat_b [N*N];
    bit        a_written [N*N];
    bit        b_written [N*N];
    longint    shadow_mod;
    int        shadow_dim [5];

    t_cmd      pending_cmds [$];
    t_prod     expected_prods [$];
    int        error_count = 0;
    int        report_count = 0;
    int        beats_in = 0;
    int        beats_out = 0;
    int        idle_cycles = 0;
    int        starts_seen = 0;
    int        mismatch_runs = 0;
    int        rx_hold_left = 0;    // cycles of long receiver hold-off still to run
    bit        no_idle = 1'b0;      // final stretch runs without idling
    bit        stim_done = 1'b0;

    function automatic int eff_dim(int d);
        if (d == 0) return 1;
        if (d > N) return N;
        return d;
    endfunction

    // Applies one accepted command to the shadow state and queues the
    // product elements it will cause.
    function automatic void predict_product(t_cmd c);
        int ar, ac, br, bc;
        longint m, acc;
        t_prod p;
        ar = eff_dim(shadow_dim[CFG_A_ROWS]);
        ac = eff_dim(shadow_dim[CFG_A_COLS]);
        br = eff_dim(shadow_dim[CFG_B_ROWS]);
        bc = eff_dim(shadow_dim[CFG_B_COLS]);
        m = (shadow_mod == 0) ? 1 : shadow_mod;
        case (c.func)
            FN_LOAD_A: mat_a[c.row*N + c.col] = longint'($signed(c.elem));
            FN_LOAD_B: mat_b[c.row*N + c.col] = longint'($signed(c.elem));
            FN_START: begin
                starts_seen++;
                if (ac != br) begin
                    mismatch_runs++;
                    p = '{row: 3'd0, col: 3'd0, value: 32'd0,
                          status: STATUS_MISMATCH, last: 1'b1};
                    expected_prods.push_back(p);
                end else begin
                    for (int i = 0; i < ar; i++) begin
                        for (int j = 0; j < bc; j++) begin
                            acc = 0;
                            for (int k = 0; k < ac; k++)
                                acc = (acc + mat_a[i*N+k] * mat_b[k*N+j]) % m;
                            p.row = i[2:0];
                            p.col = j[2:0];
                            p.value = acc[31:0];
                            p.status = STATUS_OK;
                            p.last = (i == ar-1) && (j == bc-1);
                            expected_prods.push_back(p);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Driver: takes commands from the queue, idles in random bursts.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_product('{func: i_func, row: i_row_index,
                                  col: i_col_index, elem: i_element});
                beats_in++;
            end
            if (!i_in_valid || o_in_ready) begin
                // The current beat is done or none is out: decide the next one.
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    if (!no_idle && $urandom_range(0, 9) == 0) begin
                        tx_gap <= $urandom_range(1, 17) - 1;
                        i_in_valid <= 1'b0;
                    end else begin
                        t_cmd c;
                        c = pending_cmds.pop_front();
                        i_in_valid <= 1'b1;
                        i_func <= c.func;
                        i_row_index <= c.row;
                        i_col_index <= c.col;
                        i_element <= c.elem;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each product beat against the oldest expectation and
    // drives the receiver's ready with random stall bursts.
    int rx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                t_prod exp_p;
                beats_out++;
                if (expected_prods.size() == 0) begin
                    error_count++;
                    if (report_count < 10) begin
                        report_count++;
                        $display("ERROR: unexpected product beat row %0d col %0d value %0d",
                                 o_out_row, o_out_col, $signed(o_product_value));
                    end
                end else begin
                    exp_p = expected_prods.pop_front();
                    if (exp_p != {o_out_row, o_out_col, o_product_value, o_status, o_last})
                    begin
                        error_count++;
                        if (report_count < 10) begin
                            report_count++;
                            $display("ERROR: expected r%0d c%0d v%0d s%0d l%0d, got r%0d c%0d v%0d s%0d l%0d",
                                     exp_p.row, exp_p.col, $signed(exp_p.value), exp_p.status,
                                     exp_p.last, o_out_row, o_out_col,
                                     $signed(o_product_value), o_status, o_last);
                        end
                    end
                end
            end
            if (rx_hold_left > 0) begin
                rx_hold_left <= rx_hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(1, 17) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: counts cycles in which no beat moves on either channel and no receiver hold-off runs.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (rx_hold_left > 0) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("modular_matrix_multiply_unit_tb failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input int unsigned val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[30:0];
        if (idx == CFG_MODULUS) shadow_mod = val[30:0];
        else shadow_dim[idx] = val[3:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until every queued command went in and every product came out,
    // then lets the cell chain drain before registers change.
    task automatic drain();
        while (pending_cmds.size() > 0 || i_in_valid || expected_prods.size() > 0)
            @(posedge i_clk);
        repeat (STEP_CYC * 2) @(posedge i_clk);
    endtask

    task automatic set_dims(input int unsigned md, input int ar, input int ac,
                            input int br, input int bc);
        write_reg(CFG_MODULUS, md);
        write_reg(CFG_A_ROWS, ar);
        write_reg(CFG_A_COLS, ac);
        write_reg(CFG_B_ROWS, br);
        write_reg(CFG_B_COLS, bc);
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    // Queues loads covering the full 8x8 of both stores so that no start
    // can read an entry that was never written.
    task automatic fill_all();
        t_cmd c;
        for (int r = 0; r < N; r++)
            for (int k = 0; k < N; k++) begin
                c = '{func: FN_LOAD_A, row: r, col: k, elem: rand_elem()};
                pending_cmds.push_back(c);
                c = '{func: FN_LOAD_B, row: r, col: k, elem: rand_elem()};
                pending_cmds.push_back(c);
            end
    endtask

    task automatic push_start();
        pending_cmds.push_back('{func: FN_START, row: $urandom, col: $urandom,
                                 elem: $urandom});
    endtask

    task automatic push_random_loads(input int n);
        t_cmd c;
        for (int i = 0; i < n; i++) begin
            c.func = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 1));
            c.row = $urandom;
            c.col = $urandom;
            c.elem = rand_elem();
            pending_cmds.push_back(c);
        end
    endtask

    initial begin
        int ar, ac, bc;
        foreach (mat_a[i]) begin
            mat_a[i] = 0;
            mat_b[i] = 0;
        end
        shadow_mod = 1;
        foreach (shadow_dim[i]) shadow_dim[i] = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: fill both stores, then run with reset registers.
        fill_all();
        push_start();
        // Unused func code is ignored.
        pending_cmds.push_back('{func: 2'd3, row: 3'd7, col: 3'd7, elem: 32'h1234_5678});
        push_start();
        drain();

        // Largest dimensions with the largest modulus.
        set_dims(32'h7FFF_FFFF, 8, 8, 8, 8);
        push_start();
        drain();
        // Dimension mismatch, then zero modulus and zero/over-range dims.
        set_dims(7, 2, 3, 4, 2);
        push_start();
        drain();
        set_dims(0, 0, 15, 9, 0);
        push_start();
        drain();
        set_dims(1000003, 3, 2, 2, 3);
        push_start();
        drain();

        // Sender pauses above until all results came; now a long receiver
        // hold-off while a big product fills the output path.
        set_dims($urandom_range(2, 100), 4, 2, 2, 8);
        rx_hold_left = 3000;
        push_start();
        push_random_loads(6);
        push_start();
        wait (rx_hold_left == 0);
        drain();

        // Random phases: mostly small matrices, a few large ones.
        for (int ph = 0; ph < 24; ph++) begin
            if (ph == 20) no_idle = 1'b1;
            ar = (ph % 8 == 7) ? 8 : $urandom_range(1, 3);
            ac = (ph % 8 == 7) ? 8 : $urandom_range(1, 3);
            bc = $urandom_range(1, 3);
            set_dims($urandom_range(0, 3) == 0 ? $urandom_range(1, 10) : $urandom,
                     ar, ac, ($urandom_range(0, 5) == 0) ? ac % 8 + 1 : ac, bc);
            push_random_loads(10);
            push_start();
            push_start();
            drain();
        end
        stim_done = 1'b1;
        repeat (200) @(posedge i_clk);

        $display("Covered %0d input beats, %0d starts (%0d with mismatched sizes),",
                 beats_in, starts_seen, mismatch_runs);
        $display("and %0d product beats under random stalls on both sides.", beats_out);
        if (error_count == 0 && expected_prods.size() == 0)
            $display("modular_matrix_multiply_unit_tb passed");
        else
            $display("modular_matrix_multiply_unit_tb failed");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/mmm_pkg.sv
rtl/core/mmm_ram.sv
rtl/core/mmm_cell.sv
rtl/core/modular_matrix_multiply_unit.sv
dv/modular_matrix_multiply_unit_tb.sv
